[rtl/core/vec4_normalize_top_assert.svh]
// assertion macros for the vec4 normalize top level
`ifndef VEC4_NORMALIZE_TOP_ASSERT_SVH
`define VEC4_NORMALIZE_TOP_ASSERT_SVH

// same-cycle implication
`define V4N_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define V4N_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/core/v4n_pkg.sv]
// shared constants for the vec4 normalize pipeline
package v4n_pkg;
   localparam int COMP_WIDTH_DEF = 32;
   localparam int FIELD_W        = 32;
   localparam int MAG_W          = 33;
   localparam int OUT_FRAC       = 30;
   localparam int QUOT_W         = OUT_FRAC + 1;
   localparam logic [FIELD_W-1:0] UNIT_ONE = FIELD_W'(1) << OUT_FRAC;
endpackage

[rtl/core/v4n_front.sv]
// front end: absolute values, squares and sum of squares over four stages
module v4n_front #(
   parameter int W = v4n_pkg::COMP_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  valid_in,
   input  logic [3:0][v4n_pkg::FIELD_W-1:0]      comp_in,
   output logic                                  valid_out,
   output logic [2*W:0]                          sum_out,
   output logic [3:0][W-1:0]                     mag_out,
   output logic [3:0]                            neg_out
);
   localparam int SW = 2 * W;
   localparam int PW = 2 * W + 1;

   logic [3:0]          vld_ff;
   logic [3:0][W-1:0]   mag0_ff, mag1_ff, mag2_ff, mag3_ff;
   logic [3:0]          neg0_ff, neg1_ff, neg2_ff, neg3_ff;
   logic [3:0][W-1:0]   mag0_in;
   logic [3:0]          neg0_in;
   logic [3:0][SW-1:0]  sq_ff;
   logic [1:0][PW-1:0]  pair_ff;
   logic [PW-1:0]       sum_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         neg0_in[i] = comp_in[i][W-1];
         mag0_in[i] = comp_in[i][W-1] ? (~comp_in[i][W-1:0] + W'(1)) : comp_in[i][W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag0_ff <= mag0_in;
         neg0_ff <= neg0_in;
         for (int i = 0; i < 4; i++) begin
            sq_ff[i] <= SW'(mag0_ff[i]) * SW'(mag0_ff[i]);
         end
         mag1_ff    <= mag0_ff;
         neg1_ff    <= neg0_ff;
         pair_ff[0] <= PW'(sq_ff[0]) + PW'(sq_ff[1]);
         pair_ff[1] <= PW'(sq_ff[2]) + PW'(sq_ff[3]);
         mag2_ff    <= mag1_ff;
         neg2_ff    <= neg1_ff;
         sum_ff     <= pair_ff[0] + pair_ff[1];
         mag3_ff    <= mag2_ff;
         neg3_ff    <= neg2_ff;
      end
   end

   assign valid_out = vld_ff[3];
   assign sum_out   = sum_ff;
   assign mag_out   = mag3_ff;
   assign neg_out   = neg3_ff;
endmodule

[rtl/core/v4n_sqrt.sv]
// pipelined integer square root, one result bit per stage
module v4n_sqrt #(
   parameter int W      = v4n_pkg::COMP_WIDTH_DEF,
   parameter int SIDE_W = 4 * W + 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              valid_in,
   input  logic [2*W:0]      rad_in,
   input  logic [SIDE_W-1:0] side_in,
   output logic              valid_out,
   output logic [W:0]        root_out,
   output logic [SIDE_W-1:0] side_out
);
   localparam int NS = W + 1;
   localparam int RW = W + 1;
   localparam int VW = 2 * W + 1;
   localparam int TW = 2 * W + 2;

   logic [VW-1:0]     rem_ff  [NS];
   logic [RW-1:0]     root_ff [NS];
   logic [SIDE_W-1:0] side_ff [NS];
   logic [NS-1:0]     vld_ff;
   logic [VW-1:0]     src_rem  [NS];
   logic [RW-1:0]     src_root [NS];
   logic [SIDE_W-1:0] src_side [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], valid_in};
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int B = W - s;
      logic [TW-1:0] trial;
      logic          take;

      if (s == 0) begin : g_first
         assign src_rem[s]  = rad_in;
         assign src_root[s] = '0;
         assign src_side[s] = side_in;
      end else begin : g_next
         assign src_rem[s]  = rem_ff[s-1];
         assign src_root[s] = root_ff[s-1];
         assign src_side[s] = side_ff[s-1];
      end

      assign trial = (TW'(src_root[s]) << (B + 1)) + (TW'(1) << (2 * B));
      assign take  = TW'(src_rem[s]) >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= take ? (src_rem[s] - trial[VW-1:0]) : src_rem[s];
            root_ff[s] <= take ? (src_root[s] | (RW'(1) << B)) : src_root[s];
            side_ff[s] <= src_side[s];
         end
      end
   end

   assign valid_out = vld_ff[NS-1];
   assign root_out  = root_ff[NS-1];
   assign side_out  = side_ff[NS-1];
endmodule

[rtl/core/v4n_div.sv]
// four-lane pipelined restoring divider, one quotient bit per stage
module v4n_div #(
   parameter int W = v4n_pkg::COMP_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               valid_in,
   input  logic [W:0]                         len_in,
   input  logic [3:0][W-1:0]                  mag_in,
   input  logic [3:0]                         neg_in,
   output logic                               valid_out,
   output logic [W:0]                         len_out,
   output logic [3:0][v4n_pkg::QUOT_W-1:0]    quot_out,
   output logic [3:0]                         neg_out
);
   localparam int NS = v4n_pkg::QUOT_W;
   localparam int QW = v4n_pkg::QUOT_W;
   localparam int NW = W + v4n_pkg::QUOT_W;

   logic [3:0][NW-1:0] rem_ff  [NS];
   logic [3:0][QW-1:0] quot_ff [NS];
   logic [W:0]         len_ff  [NS];
   logic [3:0]         neg_ff  [NS];
   logic [NS-1:0]      vld_ff;
   logic [3:0][NW-1:0] src_rem  [NS];
   logic [3:0][QW-1:0] src_quot [NS];
   logic [W:0]         src_len  [NS];
   logic [3:0]         src_neg  [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NS-2:0], valid_in};
      end
   end

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int B = NS - 1 - s;
      logic [NW-1:0] dsh;

      if (s == 0) begin : g_first
         for (genvar l = 0; l < 4; l++) begin : g_lane
            assign src_rem[s][l] = NW'(mag_in[l]) << v4n_pkg::OUT_FRAC;
         end
         assign src_quot[s] = '0;
         assign src_len[s]  = len_in;
         assign src_neg[s]  = neg_in;
      end else begin : g_next
         assign src_rem[s]  = rem_ff[s-1];
         assign src_quot[s] = quot_ff[s-1];
         assign src_len[s]  = len_ff[s-1];
         assign src_neg[s]  = neg_ff[s-1];
      end

      assign dsh = NW'(src_len[s]) << B;

      always_ff @(posedge clock) begin
         if (en) begin
            for (int l = 0; l < 4; l++) begin
               if (src_rem[s][l] >= dsh) begin
                  rem_ff[s][l]  <= src_rem[s][l] - dsh;
                  quot_ff[s][l] <= src_quot[s][l] | (QW'(1) << B);
               end else begin
                  rem_ff[s][l]  <= src_rem[s][l];
                  quot_ff[s][l] <= src_quot[s][l];
               end
            end
            len_ff[s] <= src_len[s];
            neg_ff[s] <= src_neg[s];
         end
      end
   end

   assign valid_out = vld_ff[NS-1];
   assign len_out   = len_ff[NS-1];
   assign quot_out  = quot_ff[NS-1];
   assign neg_out   = neg_ff[NS-1];
endmodule

[rtl/core/vec4_normalize_top.sv]
// vec4 normalize top level: pipeline assembly and output register
//
// normalizes a four-component signed fixed-point vector
// request channel: req_valid/req_ready with req_comp_x..w, low COMP_WIDTH
//   bits of each used, sign-extended from bit COMP_WIDTH-1
// response channel: rsp_valid/rsp_ready with rsp_unit_x..w (signed Q2.30),
//   rsp_magnitude (floor of the euclidean length) and rsp_zero_length
// pipeline: 4 front stages, COMP_WIDTH + 1 square root stages,
//   31 divider stages and the output register
// throughput: one request per cycle while not stalled; every stage does one fixed step
// zero vector: rsp_zero_length high, all other fields zero
// reset clears every valid bit; the first request may follow directly
// stall: while a response waits with rsp_ready low the whole pipeline
//   holds and req_ready is low; nothing is dropped or repeated
module vec4_normalize_top #(
   parameter int COMP_WIDTH = v4n_pkg::COMP_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [v4n_pkg::FIELD_W-1:0] req_comp_x,
   input  logic signed [v4n_pkg::FIELD_W-1:0] req_comp_y,
   input  logic signed [v4n_pkg::FIELD_W-1:0] req_comp_z,
   input  logic signed [v4n_pkg::FIELD_W-1:0] req_comp_w,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [v4n_pkg::FIELD_W-1:0] rsp_unit_x,
   output logic signed [v4n_pkg::FIELD_W-1:0] rsp_unit_y,
   output logic signed [v4n_pkg::FIELD_W-1:0] rsp_unit_z,
   output logic signed [v4n_pkg::FIELD_W-1:0] rsp_unit_w,
   output logic [v4n_pkg::MAG_W-1:0]          rsp_magnitude,
   output logic                               rsp_zero_length
);
   `include "vec4_normalize_top_assert.svh"

   localparam int W      = COMP_WIDTH;
   localparam int FW     = v4n_pkg::FIELD_W;
   localparam int QW     = v4n_pkg::QUOT_W;
   localparam int SIDE_W = 4 * W + 4;

   logic                      en;
   logic                      fr_valid;
   logic [2*W:0]              fr_sum;
   logic [3:0][W-1:0]         fr_mag;
   logic [3:0]                fr_neg;
   logic                      sq_valid;
   logic [W:0]                sq_root;
   logic [SIDE_W-1:0]         sq_side;
   logic                      dv_valid;
   logic [W:0]                dv_len;
   logic [3:0][QW-1:0]        dv_quot;
   logic [3:0]                dv_neg;
   logic [3:0][FW-1:0]        comp_in;
   logic [3:0][FW-1:0]        unit_in;
   logic                      zero_in;
   logic                      rsp_valid_ff;
   logic [3:0][FW-1:0]        unit_ff;
   logic [v4n_pkg::MAG_W-1:0] mag_ff;
   logic                      zero_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign comp_in   = {req_comp_w, req_comp_z, req_comp_y, req_comp_x};

   v4n_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (req_valid),
      .comp_in   (comp_in),
      .valid_out (fr_valid),
      .sum_out   (fr_sum),
      .mag_out   (fr_mag),
      .neg_out   (fr_neg)
   );

   v4n_sqrt #(.W(W), .SIDE_W(SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (fr_valid),
      .rad_in    (fr_sum),
      .side_in   ({fr_neg, fr_mag}),
      .valid_out (sq_valid),
      .root_out  (sq_root),
      .side_out  (sq_side)
   );

   v4n_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (sq_valid),
      .len_in    (sq_root),
      .mag_in    (sq_side[4*W-1:0]),
      .neg_in    (sq_side[SIDE_W-1:4*W]),
      .valid_out (dv_valid),
      .len_out   (dv_len),
      .quot_out  (dv_quot),
      .neg_out   (dv_neg)
   );

   always_comb begin
      logic [FW-1:0] q;
      zero_in = (dv_len == '0);
      for (int l = 0; l < 4; l++) begin
         q = FW'(dv_quot[l]);
         if (q > v4n_pkg::UNIT_ONE) begin
            q = v4n_pkg::UNIT_ONE;
         end
         if (zero_in) begin
            unit_in[l] = '0;
         end else if (dv_neg[l]) begin
            unit_in[l] = FW'(0) - q;
         end else begin
            unit_in[l] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unit_ff <= unit_in;
         mag_ff  <= v4n_pkg::MAG_W'(dv_len);
         zero_ff <= zero_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_unit_x      = unit_ff[0];
   assign rsp_unit_y      = unit_ff[1];
   assign rsp_unit_z      = unit_ff[2];
   assign rsp_unit_w      = unit_ff[3];
   assign rsp_magnitude   = mag_ff;
   assign rsp_zero_length = zero_ff;

   `V4N_ASSERT_IMPL(a_zero_clears, clock, reset, rsp_valid && rsp_zero_length,
      rsp_magnitude == '0 && rsp_unit_x == '0 && rsp_unit_w == '0)
   `V4N_ASSERT_IMPL(a_nonzero_len, clock, reset, rsp_valid && !rsp_zero_length,
      rsp_magnitude != '0)
   `V4N_ASSERT_IMPL(a_unit_range, clock, reset, rsp_valid,
      rsp_unit_x <= $signed(v4n_pkg::UNIT_ONE) && rsp_unit_x >= -$signed(v4n_pkg::UNIT_ONE))
   `V4N_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_magnitude))
   `V4N_ASSERT_IMPL(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready)
endmodule
